// ===== hdl/stq_pkg.sv =====
// Shared types and codes for the sorted timer expiry queue.
package stq_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned MaxResults      = 16;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdW     = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [ModeW-1:0] ModeAdd    = 2'd0;
  localparam logic [ModeW-1:0] ModeDelete = 2'd1;
  localparam logic [ModeW-1:0] ModeTick   = 2'd2;

  localparam logic [StatusW-1:0] StAdded    = 3'd0;
  localparam logic [StatusW-1:0] StRemoved  = 3'd1;
  localparam logic [StatusW-1:0] StFired    = 3'd2;
  localparam logic [StatusW-1:0] StNoneDue  = 3'd3;
  localparam logic [StatusW-1:0] StFull     = 3'd4;
  localparam logic [StatusW-1:0] StNotFound = 3'd5;

  typedef struct packed {
    logic [TimeW-1:0] expiry;
    logic [IdW-1:0]   id;
  } entry_t;

endpackage

// ===== hdl/sorted_timer_expiry_queue.sv =====
// Sorted timer expiry queue: one-port entry memory walked by a read/evaluate sequencer.
//
// Timers live in one memory in expiry order, head at address 0. An add to a non-full queue,
// a delete and a tick that fires walk the valid entries, each with a memory read and then an
// evaluate step that may write it back toward the head or the tail. in_stall_o stays high from
// the transfer until the item is done, and longer while a result waits on a stalled result
// register. A tick fires at most MaxResults (16) due timers, or Capacity if smaller; the rest
// stay at the head. Results go out through a register, so a pending result does not block the
// walk until another result has to be loaded.
// No clearing pass is needed after reset.
module sorted_timer_expiry_queue
  import stq_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [IdW-1:0]     timer_id_i,
  input  logic [TimeW-1:0]   expiry_time_i,
  input  logic [TimeW-1:0]   now_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [IdW-1:0]     fired_id_o,
  output logic [TimeW-1:0]   fired_expiry_o,
  output logic               last_result_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned FireLimit = (MaxResults < Capacity) ? MaxResults : Capacity;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SStart = 2'd1;
  localparam logic [1:0] SRead  = 2'd2;
  localparam logic [1:0] SEval  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] k_q, k_d;
  logic            flag_q, flag_d;
  entry_t          carry_q, carry_d;

  logic [ModeW-1:0] mode_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] exp_q;
  logic [TimeW-1:0] now_q;

  entry_t mem_q [Capacity];
  entry_t rd_q;
  logic            rd_en;
  logic            wr_en;
  logic [CntW-1:0] wr_idx;
  entry_t          wr_data;
  entry_t          new_entry;

  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [IdW-1:0]     fid_q;
  logic [TimeW-1:0]   fexp_q;
  logic               last_q;

  logic               emit;
  logic [StatusW-1:0] emit_status;
  logic [IdW-1:0]     emit_id;
  logic [TimeW-1:0]   emit_exp;
  logic               emit_last;

  logic out_free;
  logic have;
  logic due;

  assign in_stall_o = (state_q != SIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign have       = (idx_q < cnt_q);
  assign due        = have && (idx_q < CntW'(FireLimit)) && (rd_q.expiry <= now_q);
  assign new_entry  = '{expiry: exp_q, id: id_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    k_d         = k_q;
    flag_d      = flag_q;
    carry_d     = carry_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_data     = rd_q;
    emit        = 1'b0;
    emit_status = StAdded;
    emit_id     = id_q;
    emit_exp    = exp_q;
    emit_last   = 1'b1;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) state_d = SStart;
      end
      SStart: begin
        idx_d  = '0;
        flag_d = 1'b0;
        unique case (mode_q)
          ModeAdd: begin
            if (cnt_q == CntW'(Capacity)) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_status = StFull;
                state_d     = SIdle;
              end
            end else begin
              state_d = SRead;
            end
          end
          ModeDelete, ModeTick: state_d = SRead;
          default:              state_d = SIdle;
        endcase
      end
      SRead: begin
        rd_en   = have;
        state_d = SEval;
      end
      SEval: begin
        unique case (mode_q)
          ModeAdd: begin
            if (have) begin
              idx_d   = idx_q + 1'b1;
              state_d = SRead;
              if (flag_q) begin
                wr_en   = 1'b1;
                wr_data = carry_q;
                carry_d = rd_q;
              end else if (rd_q.expiry >= exp_q) begin
                wr_en   = 1'b1;
                wr_data = new_entry;
                carry_d = rd_q;
                flag_d  = 1'b1;
              end
            end else if (out_free) begin
              wr_en       = 1'b1;
              wr_data     = flag_q ? carry_q : new_entry;
              cnt_d       = cnt_q + 1'b1;
              emit        = 1'b1;
              emit_status = StAdded;
              state_d     = SIdle;
            end
          end
          ModeDelete: begin
            if (have) begin
              idx_d   = idx_q + 1'b1;
              state_d = SRead;
              if (flag_q) begin
                wr_en  = 1'b1;
                wr_idx = idx_q - 1'b1;
              end else if (rd_q.id == id_q) begin
                flag_d  = 1'b1;
                carry_d = rd_q;
              end
            end else if (out_free) begin
              emit        = 1'b1;
              emit_status = flag_q ? StRemoved : StNotFound;
              emit_exp    = flag_q ? carry_q.expiry : '0;
              if (flag_q) cnt_d = cnt_q - 1'b1;
              state_d = SIdle;
            end
          end
          ModeTick: begin
            if (flag_q) begin
              // compact the survivors toward the head
              if (have) begin
                wr_en   = 1'b1;
                wr_idx  = idx_q - k_q;
                idx_d   = idx_q + 1'b1;
                state_d = SRead;
              end else begin
                cnt_d   = cnt_q - k_q;
                state_d = SIdle;
              end
            end else if (due) begin
              // held head is known not to be last once the next one is due
              if (idx_q == '0) begin
                carry_d = rd_q;
                idx_d   = idx_q + 1'b1;
                state_d = SRead;
              end else if (out_free) begin
                emit        = 1'b1;
                emit_status = StFired;
                emit_id     = carry_q.id;
                emit_exp    = carry_q.expiry;
                emit_last   = 1'b0;
                carry_d     = rd_q;
                idx_d       = idx_q + 1'b1;
                state_d     = SRead;
              end
            end else if (out_free) begin
              emit = 1'b1;
              if (idx_q == '0) begin
                emit_status = StNoneDue;
                emit_id     = '0;
                emit_exp    = '0;
                state_d     = SIdle;
              end else begin
                emit_status = StFired;
                emit_id     = carry_q.id;
                emit_exp    = carry_q.expiry;
              end
              flag_d = 1'b1;
              k_d    = idx_q;
            end
          end
          default: state_d = SIdle;
        endcase
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx[IdxW-1:0]] <= wr_data;
    if (rd_en) rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (in_valid_i && !in_stall_o) begin
      mode_q <= mode_i;
      id_q   <= timer_id_i;
      exp_q  <= expiry_time_i;
      now_q  <= now_time_i;
    end
    if (emit) begin
      status_q <= emit_status;
      fid_q    <= emit_id;
      fexp_q   <= emit_exp;
      last_q   <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      flag_q  <= flag_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign fired_id_o     = fid_q;
  assign fired_expiry_o = fexp_q;
  assign last_result_o  = last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result loaded over a stalled result");

  a_add_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEval && mode_q == ModeAdd) |-> cnt_q < CntW'(Capacity))
    else $error("insert walk on a full queue");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> wr_idx <= cnt_q)
    else $error("write beyond the valid entries");
`endif

endmodule

// ===== tb/timer_queue_checker.sv =====
// Result checker for the sorted timer expiry queue: predicts each transfer and compares fields.
`timescale 1ns / 100ps
module timer_queue_checker
  import stq_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [IdW-1:0]     timer_id_i,
  input  logic [TimeW-1:0]   expiry_time_i,
  input  logic [TimeW-1:0]   now_time_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [IdW-1:0]     fired_id_i,
  input  logic [TimeW-1:0]   fired_expiry_i,
  input  logic               last_result_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_count_o
);

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [TimeW-1:0]   expiry;
    logic               last;
  } timer_result_t;

  entry_t        timer_list[$];
  timer_result_t awaited_results[$];
  int unsigned   mismatches = 0;

  assign error_count_o = mismatches;

  function automatic void post_result(input logic [StatusW-1:0] st, input logic [IdW-1:0] id,
                                      input logic [TimeW-1:0] expiry, input logic last);
    timer_result_t r;
    r.status = st;
    r.id     = id;
    r.expiry = expiry;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_timer_op(input logic [ModeW-1:0] op,
                                           input logic [IdW-1:0] id,
                                           input logic [TimeW-1:0] expiry,
                                           input logic [TimeW-1:0] now);
    int     pos;
    int     fired;
    entry_t e;
    pos   = 0;
    fired = 0;
    unique case (op)
      ModeAdd: begin
        if (timer_list.size() >= Capacity) begin
          post_result(StFull, id, expiry, 1'b1);
        end else begin
          // new entry goes ahead of equal expiries
          while (pos < timer_list.size() && timer_list[pos].expiry < expiry) pos++;
          e.expiry = expiry;
          e.id     = id;
          timer_list.insert(pos, e);
          post_result(StAdded, id, expiry, 1'b1);
        end
      end
      ModeDelete: begin
        while (pos < timer_list.size() && timer_list[pos].id != id) pos++;
        if (pos < timer_list.size()) begin
          post_result(StRemoved, id, timer_list[pos].expiry, 1'b1);
          timer_list.delete(pos);
        end else begin
          post_result(StNotFound, id, '0, 1'b1);
        end
      end
      ModeTick: begin
        while (fired < MaxResults && timer_list.size() > 0 && timer_list[0].expiry <= now) begin
          e = timer_list.pop_front();
          post_result(StFired, e.id, e.expiry, 1'b0);
          fired++;
        end
        if (fired == 0) begin
          post_result(StNoneDue, '0, '0, 1'b1);
        end else begin
          awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [TimeW-1:0] want,
                                        input logic [TimeW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni) begin
      // result transfer first: it can never belong to an item taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: status %0d, id 0x%0h", status_i, fired_id_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", TimeW'(want.status), TimeW'(status_i));
          compare_field("fired_id", TimeW'(want.id), TimeW'(fired_id_i));
          compare_field("fired_expiry", want.expiry, fired_expiry_i);
          compare_field("last_result", TimeW'(want.last), TimeW'(last_result_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_timer_op(mode_i, timer_id_i, expiry_time_i, now_time_i);
      end
    end
    pending_count_o <= awaited_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the sorted timer expiry queue: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb
  import stq_pkg::*;
();

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  localparam int unsigned RandomOps  = 150;
  localparam int unsigned HoldAt     = 40;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietFrom  = 100;
  localparam int unsigned QuietTo    = 140;
  localparam int unsigned IdleLimit  = 2000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ModeW-1:0]   mode;
  logic [IdW-1:0]     timer_id;
  logic [TimeW-1:0]   expiry_time;
  logic [TimeW-1:0]   now_time;
  logic               out_valid;
  logic               out_stall;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     fired_id;
  logic [TimeW-1:0]   fired_expiry;
  logic               last_result;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned ops_sent    = 0;
  int unsigned idle_cycles = 0;

  sorted_timer_expiry_queue i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .timer_id_i    (timer_id),
    .expiry_time_i (expiry_time),
    .now_time_i    (now_time),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .fired_id_o    (fired_id),
    .fired_expiry_o(fired_expiry),
    .last_result_o (last_result)
  );

  timer_queue_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .timer_id_i     (timer_id),
    .expiry_time_i  (expiry_time),
    .now_time_i     (now_time),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .fired_id_i     (fired_id),
    .fired_expiry_i (fired_expiry),
    .last_result_i  (last_result),
    .error_count_o  (error_count),
    .pending_count_o(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // no idling inside the quiet window
  function automatic bit idle_roll();
    return (ops_sent < QuietFrom || ops_sent >= QuietTo) && $urandom_range(99) < 21;
  endfunction

  // mostly a small pool so deletes find their timers
  function automatic logic [IdW-1:0] pick_id();
    return ($urandom_range(99) < 80) ? IdW'($urandom_range(23)) : IdW'($urandom_range(255));
  endfunction

  task automatic offer_op(input logic [ModeW-1:0] op, input logic [IdW-1:0] id,
                          input logic [TimeW-1:0] expiry, input logic [TimeW-1:0] now);
    in_valid    <= 1'b1;
    mode        <= op;
    timer_id    <= id;
    expiry_time <= expiry;
    now_time    <= now;
    do @(posedge clk); while (in_stall);
    ops_sent++;
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    logic [TimeW-1:0] sim_now;
    int unsigned      pick;
    bit               fill_phase;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    mode        = ModeAdd;
    timer_id    = '0;
    expiry_time = '0;
    now_time    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    offer_op(ModeTick, 8'd0, '0, '0);
    offer_op(ModeDelete, 8'd0, '0, '0);
    offer_op(ModeAdd, 8'd0, 32'd0, '0);
    offer_op(ModeAdd, 8'hFF, 32'hFFFF_FFFF, '0);
    offer_op(ModeAdd, 8'hAA, 32'd100, '0);
    offer_op(ModeAdd, 8'h55, 32'd100, '0);
    offer_op(ModeAdd, 8'hAA, 32'd50, '0);
    offer_op(ModeDelete, 8'hAA, '0, '0);
    offer_op(ModeTick, 8'd0, '0, 32'd99);
    for (int k = 0; k < 13; k++) begin
      offer_op(ModeAdd, IdW'(k + 1), TimeW'($urandom_range(1000)), '0);
    end
    offer_op(ModeAdd, 8'h77, 32'd5, '0);
    offer_op(ModeUnused, 8'h33, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_op(ModeTick, 8'd0, '0, 32'hFFFF_FFFF);
    offer_op(ModeTick, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    sim_now = $urandom();
    for (int k = 0; k < RandomOps; k++) begin
      fill_phase = ((k / 30) % 2) == 0;
      pick       = $urandom_range(99);
      if ($urandom_range(99) < 4) begin
        offer_op(ModeUnused, pick_id(), $urandom(), $urandom());
      end
      if (pick < (fill_phase ? 70 : 30)) begin
        offer_op(ModeAdd, pick_id(),
                 ($urandom_range(99) < 10) ? $urandom() : sim_now + $urandom_range(60),
                 $urandom());
      end else if (pick < (fill_phase ? 80 : 55)) begin
        offer_op(ModeDelete, pick_id(), $urandom(), $urandom());
      end else begin
        sim_now = ($urandom_range(99) < 6) ? $urandom() : sim_now + $urandom_range(30);
        offer_op(ModeTick, pick_id(), $urandom(), sim_now);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2 * DefaultCapacity + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    bit held_off;
    held_off  = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && ops_sent >= HoldAt) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= idle_roll();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
